// ===== design/mbrc_pkg.sv =====
package mbrc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Address, function, count and two CRC bytes.
    localparam int MIN_FRAME_LEN = 5;
    // Address, function and count precede the data.
    localparam int HEADER_LEN = 3;

    localparam logic [7:0] ADDRESS_RESET  = 8'd1;
    localparam logic [7:0] FUNCTION_RESET = 8'd4;

    localparam logic REG_ADDRESS  = 1'b0;
    localparam logic REG_FUNCTION = 1'b1;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_LENGTH = 3'd2,
        ST_HEADER = 3'd3,
        ST_CRC    = 3'd4
    } status_t;

endpackage

// ===== design/mbrc_crc16_byte.sv =====
module mbrc_crc16_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    // Reflected CRC-16, one bit per step over the eight bits of the byte.
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ mbrc_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== design/modbus_rtu_response_checker.sv =====
// Checks a Modbus RTU response that arrives one byte per item, tlast on the
// frame's last byte. Each complete big-endian data word comes out as an item
// with tuser low and its word index; the last byte of a frame gives one
// status item with tuser and tlast high (too short, length mismatch, header
// mismatch or CRC error, in that priority, else ok). The block can take one
// byte every cycle unless m_tready holds it back: the CRC update of a whole
// byte and the header and length checks all settle combinationally ahead of the
// output register, which offers each result the cycle after its byte. A byte
// is taken in any cycle in which the output register is empty or its item
// is being taken, so a result held back by m_tready holds the input back too.
// Frames longer than MAX_FRAME_BYTES stop emitting words and end with length
// mismatch. Expected address sits at byte address 0 and expected function at 4.
module modbus_rtu_response_checker #(
    parameter int MAX_FRAME_BYTES = mbrc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] word_value, [22:16] word_index,
                                   // [25:23] status, [31:26] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CmpW = (PosW + 1 > 9) ? PosW + 1 : 9;
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

    logic [7:0]      address_reg;
    logic [7:0]      function_reg;

    logic [PosW-1:0] pos_reg,    pos_next;
    logic [7:0]      count_reg,  count_next;
    logic            hdr_reg,    hdr_next;
    logic [15:0]     crc_reg,    crc_next;
    logic [7:0]      dly0_reg,   dly0_next;
    logic [7:0]      dly1_reg,   dly1_next;
    logic [7:0]      hold_reg,   hold_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_kind_reg;
    logic [15:0]     out_value_reg;
    logic [6:0]      out_index_reg;
    logic [2:0]      out_status_reg;

    logic            accept;
    logic [7:0]      b;
    logic            saturated;
    logic [15:0]     crc_step;
    logic [15:0]     crc_fed;
    logic            hdr_now;
    logic [CmpW-1:0] len;
    logic [CmpW-1:0] exp_len;
    logic [CmpW-1:0] data_off;
    logic            in_data;
    logic            word_fire;
    mbrc_pkg::status_t status_now;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg  <= mbrc_pkg::ADDRESS_RESET;
            function_reg <= mbrc_pkg::FUNCTION_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                mbrc_pkg::REG_ADDRESS:  address_reg  <= pwdata[7:0];
                mbrc_pkg::REG_FUNCTION: function_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mbrc_pkg::REG_ADDRESS:  prdata = {24'h0, address_reg};
            mbrc_pkg::REG_FUNCTION: prdata = {24'h0, function_reg};
            default:                prdata = '0;
        endcase
    end

    // Byte path.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    mbrc_crc16_byte u_crc (
        .crc_in  (crc_reg),
        .data    (dly1_reg),
        .crc_out (crc_step)
    );

    // The CRC trails the input by two bytes, so the last two bytes never
    // enter it and can be compared against it directly.
    assign saturated = pos_reg >= PosMax;
    assign crc_fed   = (pos_reg >= PosW'(2)) ? crc_step : crc_reg;
    assign hdr_now   = hdr_reg
                       && !(pos_reg == PosW'(0) && b != address_reg)
                       && !(pos_reg == PosW'(1) && b != function_reg);
    assign len       = CmpW'(pos_reg) + CmpW'(1);
    assign exp_len   = CmpW'(count_reg) + CmpW'(mbrc_pkg::MIN_FRAME_LEN);
    assign data_off  = CmpW'(pos_reg) - CmpW'(mbrc_pkg::HEADER_LEN);
    assign in_data   = !saturated && (pos_reg >= PosW'(mbrc_pkg::HEADER_LEN))
                       && (data_off < CmpW'(count_reg));
    assign word_fire = !s_tlast && in_data && data_off[0];

    always_comb
    begin
        if (len < CmpW'(mbrc_pkg::MIN_FRAME_LEN))
        begin
            status_now = mbrc_pkg::ST_SHORT;
        end
        else if (saturated || len != exp_len)
        begin
            status_now = mbrc_pkg::ST_LENGTH;
        end
        else if (!hdr_now)
        begin
            status_now = mbrc_pkg::ST_HEADER;
        end
        else if ({b, dly0_reg} != crc_fed)
        begin
            status_now = mbrc_pkg::ST_CRC;
        end
        else
        begin
            status_now = mbrc_pkg::ST_OK;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        hdr_next   = hdr_reg;
        crc_next   = crc_reg;
        dly0_next  = dly0_reg;
        dly1_next  = dly1_reg;
        hold_next  = hold_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_next   = '0;
                count_next = '0;
                hdr_next   = 1'b1;
                crc_next   = mbrc_pkg::CRC_INIT;
                dly0_next  = '0;
                dly1_next  = '0;
                hold_next  = '0;
            end
            else
            begin
                crc_next  = crc_fed;
                hdr_next  = hdr_now;
                dly1_next = dly0_reg;
                dly0_next = b;
                if (pos_reg == PosW'(2))
                begin
                    count_next = b;
                end
                if (in_data && !data_off[0])
                begin
                    hold_next = b;
                end
                if (!saturated)
                begin
                    pos_next = pos_reg + PosW'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = s_tlast || word_fire;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            hdr_reg       <= 1'b1;
            crc_reg       <= mbrc_pkg::CRC_INIT;
            dly0_reg      <= '0;
            dly1_reg      <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            hdr_reg       <= hdr_next;
            crc_reg       <= crc_next;
            dly0_reg      <= dly0_next;
            dly1_reg      <= dly1_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (s_tlast)
            begin
                out_kind_reg   <= mbrc_pkg::KIND_STATUS;
                out_value_reg  <= '0;
                out_index_reg  <= '0;
                out_status_reg <= status_now;
            end
            else
            begin
                // The word index fits seven bits because the offset is
                // below an eight-bit byte count.
                out_kind_reg   <= mbrc_pkg::KIND_WORD;
                out_value_reg  <= {hold_reg, b};
                out_index_reg  <= data_off[7:1];
                out_status_reg <= mbrc_pkg::ST_OK;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'h00, out_status_reg, out_index_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_kind_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[25:23] == mbrc_pkg::ST_OK)
        else $error("word item carries a non-zero status");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> pos_reg == '0 && crc_reg == mbrc_pkg::CRC_INIT)
        else $error("frame state not cleared after the last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PosMax)
        else $error("byte position beyond the frame limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> m_tvalid && m_tuser)
        else $error("last byte gave no status item");

endmodule

// ===== dv/testbench.sv =====
module testbench;

    localparam int FRAME_LIMIT = mbrc_pkg::MAX_FRAME_BYTES_DEF;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } rx_item_t;

    typedef struct {
        logic              kind;
        logic [15:0]       value;
        logic [6:0]        index;
        mbrc_pkg::status_t st;
        logic              last;
    } response_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [15:0] word_value, [22:16] word_index, [25:23] status
    logic        m_tuser;   // kind
    logic        m_tlast;   // last

    modbus_rtu_response_checker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    rx_item_t  rx_bytes_q[$];
    response_t expected_results[$];

    // Expected-response state, kept alongside the block.
    logic [7:0]  exp_address = mbrc_pkg::ADDRESS_RESET;
    logic [7:0]  exp_function = mbrc_pkg::FUNCTION_RESET;
    int          frame_pos = 0;
    logic [7:0]  frame_count = '0;
    bit          hdr_good = 1'b1;
    logic [15:0] frame_crc = mbrc_pkg::CRC_INIT;
    logic [7:0]  lag_bytes[2] = '{8'h00, 8'h00};
    logic [7:0]  word_high = '0;

    bit in_accepted = 1'b0;
    bit idle_on = 1'b1;
    int send_gap = 0;
    int recv_gap = 0;
    int errors = 0;
    int queued_items = 0;
    int words_checked = 0;
    int frames_checked = 0;
    int status_seen[5] = '{0, 0, 0, 0, 0};

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ mbrc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic clear_frame();
        frame_pos = 0;
        frame_count = '0;
        hdr_good = 1'b1;
        frame_crc = mbrc_pkg::CRC_INIT;
        lag_bytes = '{8'h00, 8'h00};
        word_high = '0;
    endtask

    task automatic predict_response_byte(input logic [7:0] b, input logic fin);
        int          p;
        int          d;
        int          idx;
        bit          sat;
        logic [15:0] rx_crc;
        response_t   r;
        p = frame_pos;
        sat = p >= FRAME_LIMIT;
        // The running CRC lags two bytes so the trailing CRC bytes never enter it.
        if (p >= 2)
            frame_crc = crc16_byte(frame_crc, lag_bytes[1]);
        if (p == 0 && b != exp_address)
            hdr_good = 1'b0;
        if (p == 1 && b != exp_function)
            hdr_good = 1'b0;
        if (fin)
        begin
            rx_crc = {b, lag_bytes[0]};
            r.kind = mbrc_pkg::KIND_STATUS;
            r.value = '0;
            r.index = '0;
            r.last = 1'b1;
            if (p + 1 < mbrc_pkg::MIN_FRAME_LEN)
                r.st = mbrc_pkg::ST_SHORT;
            else if (sat || p + 1 != mbrc_pkg::MIN_FRAME_LEN + int'(frame_count))
                r.st = mbrc_pkg::ST_LENGTH;
            else if (!hdr_good)
                r.st = mbrc_pkg::ST_HEADER;
            else if (rx_crc != frame_crc)
                r.st = mbrc_pkg::ST_CRC;
            else
                r.st = mbrc_pkg::ST_OK;
            expected_results = {expected_results, r};
            status_seen[int'(r.st)]++;
            clear_frame();
        end
        else
        begin
            if (p == 2)
                frame_count = b;
            if (!sat && p >= mbrc_pkg::HEADER_LEN)
            begin
                d = p - mbrc_pkg::HEADER_LEN;
                if (d < int'(frame_count))
                begin
                    if (d % 2 == 0)
                    begin
                        word_high = b;
                    end
                    else
                    begin
                        idx = d / 2;
                        if (idx > 127)
                            idx = 127;
                        r.kind = mbrc_pkg::KIND_WORD;
                        r.value = {word_high, b};
                        r.index = idx[6:0];
                        r.st = mbrc_pkg::ST_OK;
                        r.last = 1'b0;
                        expected_results = {expected_results, r};
                    end
                end
            end
            lag_bytes[1] = lag_bytes[0];
            lag_bytes[0] = b;
            if (!sat)
                frame_pos = p + 1;
        end
    endtask

    // Input side: inputs settle at the falling edge, acceptance is seen at the rising one.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && in_accepted)
                void'(rx_bytes_q.pop_front());
            if (s_tvalid && !in_accepted)
            begin
                // An offered item stays put until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (rx_bytes_q.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_bytes_q[0].data;
                s_tlast <= rx_bytes_q[0].fin;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        response_t want;
        if (!rst_n)
        begin
            in_accepted = 1'b0;
        end
        else
        begin
            in_accepted = s_tvalid && s_tready;
            if (in_accepted)
                predict_response_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item, tdata %h tuser %b",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %b, expected %b", m_tuser, want.kind));
                    if (m_tdata[15:0] !== want.value)
                        report_mismatch($sformatf("word value %h, expected %h",
                                                  m_tdata[15:0], want.value));
                    if (m_tdata[22:16] !== want.index)
                        report_mismatch($sformatf("word index %0d, expected %0d",
                                                  m_tdata[22:16], want.index));
                    if (m_tdata[25:23] !== want.st)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  m_tdata[25:23], want.st.name()));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
                    if (want.kind == mbrc_pkg::KIND_WORD)
                        words_checked++;
                    else
                        frames_checked++;
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        rx_item_t it;
        it.data = b;
        it.fin = fin;
        rx_bytes_q = {rx_bytes_q, it};
        queued_items++;
    endtask

    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func,
                               input int count, input int ndata, input bit bad_crc);
        logic [7:0]  body[$];
        logic [15:0] c;
        body = {body, addr};
        body = {body, func};
        body = {body, count[7:0]};
        for (int i = 0; i < ndata; i++)
            body = {body, 8'($urandom_range(0, 255))};
        c = mbrc_pkg::CRC_INIT;
        foreach (body[i])
            c = crc16_byte(c, body[i]);
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        body = {body, c[7:0]};
        body = {body, c[15:8]};
        foreach (body[i])
            push_byte(body[i], i == body.size() - 1);
    endtask

    // Raw bytes; with scatter set, frame ends also fall at random inside the run.
    task automatic queue_raw(input int len, input bit scatter);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)),
                      i == len - 1 || (scatter && $urandom_range(0, 7) == 0));
    endtask

    task automatic random_frames(input int budget);
        int first;
        int pick;
        int count;
        first = queued_items;
        while (queued_items - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(0, 40);
            else
                count = $urandom_range(0, 10);
            if (pick < 60)
                queue_frame(exp_address, exp_function, count, count, 1'b0);
            else if (pick < 65)
                queue_frame(8'($urandom_range(0, 255)), exp_function, count, count, 1'b0);
            else if (pick < 70)
                queue_frame(exp_address, 8'($urandom_range(0, 255)), count, count, 1'b0);
            else if (pick < 78)
                queue_frame(exp_address, exp_function, count, count, 1'b1);
            else if (pick < 88)
                queue_frame(exp_address, exp_function, count,
                            count + $urandom_range(1, 3) - ((count > 2) ? 3 : 0),
                            $urandom_range(0, 1));
            else if (pick < 94)
                queue_raw($urandom_range(1, 4), 1'b0);
            else
                queue_raw($urandom_range(1, 20), 1'b1);
        end
    endtask

    task automatic wait_idle();
        while (rx_bytes_q.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [7:0] value);
        logic [31:0] noise;
        noise = $urandom();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= {noise[31:8], value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (sel == mbrc_pkg::REG_ADDRESS)
            exp_address = value;
        else
            exp_function = value;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[7:0] !== value)
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      sel, prdata[7:0], value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset register values.
        push_byte(8'h01, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        begin
            logic [15:0] c;
            c = mbrc_pkg::CRC_INIT;
            c = crc16_byte(c, 8'h01);
            c = crc16_byte(c, 8'h04);
            c = crc16_byte(c, 8'h04);
            c = crc16_byte(c, 8'h00);
            c = crc16_byte(c, 8'h00);
            c = crc16_byte(c, 8'hFF);
            c = crc16_byte(c, 8'hFF);
            push_byte(c[7:0], 1'b0);
            push_byte(c[15:8], 1'b1);
        end
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        queue_frame(8'h00, mbrc_pkg::FUNCTION_RESET, 0, 0, 1'b0);
        queue_frame(mbrc_pkg::ADDRESS_RESET, mbrc_pkg::FUNCTION_RESET, 0, 0, 1'b1);
        wait_idle();

        // Lowest register values; a frame exactly at the length limit.
        write_reg(mbrc_pkg::REG_ADDRESS, 8'h00);
        write_reg(mbrc_pkg::REG_FUNCTION, 8'h00);
        queue_frame(exp_address, exp_function, FRAME_LIMIT - 5, FRAME_LIMIT - 5, 1'b0);
        random_frames(300);
        wait_idle();

        // Highest values; a frame whose count runs past the limit.
        write_reg(mbrc_pkg::REG_ADDRESS, 8'hFF);
        write_reg(mbrc_pkg::REG_FUNCTION, 8'hFF);
        queue_frame(exp_address, exp_function, 255, 255, 1'b0);
        random_frames(300);
        wait_idle();

        // Random values, no idling on either side; one byte over the limit.
        write_reg(mbrc_pkg::REG_ADDRESS, 8'($urandom_range(0, 255)));
        write_reg(mbrc_pkg::REG_FUNCTION, 8'($urandom_range(0, 255)));
        idle_on = 1'b0;
        queue_frame(exp_address, exp_function, FRAME_LIMIT - 5, FRAME_LIMIT - 4, 1'b0);
        random_frames(300);
        wait_idle();
        repeat (10) @(posedge clk);

        while (expected_results.size() != 0)
        begin
            report_mismatch("expected result never arrived");
            void'(expected_results.pop_front());
        end
        $display("covered %0d input items: %0d frames and %0d register words checked",
                 queued_items, frames_checked, words_checked);
        $display("status mix: ok %0d, short %0d, length %0d, header %0d, crc %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbrc_pkg.sv
design/mbrc_crc16_byte.sv
design/modbus_rtu_response_checker.sv
dv/testbench.sv
